/* design/hrid_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// hrid_pkg
// shared widths, defaults and lane result type for the input debouncer
// ---------------------------------------------------------------------------
package hrid_pkg;

  localparam int BYTE_W            = 8;
  localparam int WORD_PORTS        = 4;
  localparam int IN_W              = 32;
  localparam int CHG_W             = 8;
  localparam int OUT_W             = IN_W + CHG_W;

  localparam int PORT_COUNT_DEF    = 4;
  localparam int HOLD_DEPTH_DEF    = 4;
  localparam int REPRESS_DEPTH_DEF = 8;

  // per-port lane result
  typedef struct packed {
    logic [BYTE_W-1:0] changed;
    logic [BYTE_W-1:0] stable;
  } lane_res_t;

  // ports that fit in the 32-bit scan word
  function automatic int active_lanes(input int ports);
    return (ports > WORD_PORTS) ? WORD_PORTS : ports;
  endfunction

  // slot index width for a ring of the given depth
  function automatic int slot_width(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage
`default_nettype wire

/* design/hold_repress_input_debouncer_core.sv */
`default_nettype none
// an accepted scan's result is registered, then leaves on out_* after any older result
// throughput: one scan per cycle, limited only by the two-entry result buffer
// in_tready stays high while that buffer has a free entry, independent of out_tready
// reset (rst_n low, synchronous): stable vector, hold and repress rings, both ring
// slots and the result buffer count and pointers are cleared; no clearing pass is needed
// ---------------------------------------------------------------------------
// hold_repress_input_debouncer_core
// per-pin debouncer: rise gated by a repress history of rise vectors taken before the fall step,
// fall gated by a hold history of raw scans; one lane per 8-pin port
// ---------------------------------------------------------------------------
module hold_repress_input_debouncer_core #(
  parameter int PORT_COUNT    = hrid_pkg::PORT_COUNT_DEF,
  parameter int HOLD_DEPTH    = hrid_pkg::HOLD_DEPTH_DEF,
  parameter int REPRESS_DEPTH = hrid_pkg::REPRESS_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // scan input
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [hrid_pkg::IN_W-1:0]  in_tdata,   // [31:0] sample_bits
  // debounced result
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [hrid_pkg::OUT_W-1:0]      out_tdata   // [31:0] stable_bits, [39:32] changed_positions
);

  // ports beyond the 32-bit word are never used
  localparam int LANES = hrid_pkg::active_lanes(PORT_COUNT);
  localparam int HW    = hrid_pkg::slot_width(HOLD_DEPTH);
  localparam int RW    = hrid_pkg::slot_width(REPRESS_DEPTH);
  localparam logic [hrid_pkg::IN_W-1:0] LANE_MASK =
    hrid_pkg::IN_W'((64'd1 << (hrid_pkg::BYTE_W * LANES)) - 64'd1);

  logic                          in_acc;
  logic                          has_room;
  logic [HW-1:0]                 hold_slot_r;
  logic [HW-1:0]                 hold_slot_nxt;
  logic [RW-1:0]                 repress_slot_r;
  logic [RW-1:0]                 repress_slot_nxt;
  hrid_pkg::lane_res_t           lane_res [LANES];
  logic [hrid_pkg::IN_W-1:0]     stable_bits;
  logic [hrid_pkg::CHG_W-1:0]    changed_positions;

  assign in_tready = has_room;
  assign in_acc    = in_tvalid & in_tready;

  // ring slots are shared by every lane, advancing once per accepted scan
  always_comb begin
    hold_slot_nxt    = (hold_slot_r == HW'(HOLD_DEPTH - 1)) ? '0 : hold_slot_r + HW'(1);
    repress_slot_nxt = (repress_slot_r == RW'(REPRESS_DEPTH - 1)) ? '0
                                                                 : repress_slot_r + RW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_slot_r    <= '0;
      repress_slot_r <= '0;
    end else if (in_acc) begin
      hold_slot_r    <= hold_slot_nxt;
      repress_slot_r <= repress_slot_nxt;
    end
  end

  // one debounce lane per active port byte
  for (genvar p = 0; p < LANES; p++) begin : g_lane
    hrid_lane #(
      .HOLD_DEPTH    (HOLD_DEPTH),
      .REPRESS_DEPTH (REPRESS_DEPTH)
    ) u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .accept       (in_acc),
      .sample       (in_tdata[p*hrid_pkg::BYTE_W +: hrid_pkg::BYTE_W]),
      .hold_slot    (hold_slot_r),
      .repress_slot (repress_slot_r),
      .res          (lane_res[p])
    );
  end

  // combine lane bytes; change mask is the OR across ports
  hrid_merge #(
    .LANES (LANES)
  ) u_merge (
    .res               (lane_res),
    .stable_bits       (stable_bits),
    .changed_positions (changed_positions)
  );

  // result word registered here, decoupling the two handshakes
  hrid_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_acc),
    .push_data  ({changed_positions, stable_bits}),
    .has_room   (has_room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTH
  // an accepted scan always leaves a result waiting
  a_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_tvalid)
    else $error("no result after accepted scan");

  // pins of unused ports never read high
  a_unused_ports_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[hrid_pkg::IN_W-1:0] & ~LANE_MASK) == '0))
    else $error("unused port bits set in stable vector");

  // back-pressure only when the buffer really holds results
  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty result buffer");

  // hold slot stays inside its ring
  a_hold_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    hold_slot_r <= HW'(HOLD_DEPTH - 1))
    else $error("hold slot out of range");
`endif

endmodule
`default_nettype wire

/* design/hrid_lane.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// hrid_lane
// debounce core for one 8-pin port: repress and hold rings plus stable byte
// ---------------------------------------------------------------------------
module hrid_lane #(
  parameter int HOLD_DEPTH    = hrid_pkg::HOLD_DEPTH_DEF,
  parameter int REPRESS_DEPTH = hrid_pkg::REPRESS_DEPTH_DEF,
  localparam int HW           = hrid_pkg::slot_width(HOLD_DEPTH),
  localparam int RW           = hrid_pkg::slot_width(REPRESS_DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        accept,
  input  wire logic [hrid_pkg::BYTE_W-1:0] sample,
  input  wire logic [HW-1:0]               hold_slot,
  input  wire logic [RW-1:0]               repress_slot,
  output hrid_pkg::lane_res_t              res
);

  logic [hrid_pkg::BYTE_W-1:0] hold_r    [HOLD_DEPTH];
  logic [hrid_pkg::BYTE_W-1:0] repress_r [REPRESS_DEPTH];
  logic [hrid_pkg::BYTE_W-1:0] stable_r;
  logic [hrid_pkg::BYTE_W-1:0] stable_nxt;
  logic [hrid_pkg::BYTE_W-1:0] rise;
  logic [hrid_pkg::BYTE_W-1:0] seen_rep;
  logic [hrid_pkg::BYTE_W-1:0] seen_hold;

  always_comb begin
    seen_rep = '0;
    for (int j = 0; j < REPRESS_DEPTH; j++) begin
      seen_rep = seen_rep | repress_r[j];
    end
    rise = stable_r | (sample & ~seen_rep);
    // hold history including this scan in place of the slot it overwrites
    seen_hold = sample;
    for (int j = 0; j < HOLD_DEPTH; j++) begin
      if (HW'(j) != hold_slot) begin
        seen_hold = seen_hold | hold_r[j];
      end
    end
    stable_nxt  = rise & seen_hold;
    res.stable  = stable_nxt;
    res.changed = stable_nxt ^ stable_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= '0;
      for (int j = 0; j < HOLD_DEPTH; j++) begin
        hold_r[j] <= '0;
      end
      for (int j = 0; j < REPRESS_DEPTH; j++) begin
        repress_r[j] <= '0;
      end
    end else if (accept) begin
      stable_r                <= stable_nxt;
      hold_r[hold_slot]       <= sample;
      repress_r[repress_slot] <= rise;
    end
  end

endmodule
`default_nettype wire

/* design/hrid_merge.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// hrid_merge
// gathers lane bytes into the stable vector and folds the change masks
// ---------------------------------------------------------------------------
module hrid_merge #(
  parameter int LANES = hrid_pkg::WORD_PORTS
) (
  input  wire hrid_pkg::lane_res_t         res [LANES],
  output logic [hrid_pkg::IN_W-1:0]        stable_bits,
  output logic [hrid_pkg::CHG_W-1:0]       changed_positions
);

  always_comb begin
    stable_bits       = '0;
    changed_positions = '0;
    for (int p = 0; p < LANES; p++) begin
      stable_bits[p*hrid_pkg::BYTE_W +: hrid_pkg::BYTE_W] = res[p].stable;
      changed_positions = changed_positions | res[p].changed;
    end
  end

endmodule
`default_nettype wire

/* design/hrid_outbuf.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// hrid_outbuf
// two-entry result buffer so input acceptance does not wait on out_tready
// ---------------------------------------------------------------------------
module hrid_outbuf (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  input  wire logic [hrid_pkg::OUT_W-1:0]   push_data,
  output logic                              has_room,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [hrid_pkg::OUT_W-1:0]        out_tdata
);

  logic [hrid_pkg::OUT_W-1:0] buf_r [2];
  logic                       wr_ptr_r;
  logic                       rd_ptr_r;
  logic [1:0]                 count_r;
  logic [1:0]                 count_nxt;
  logic                       pop;

  assign out_tvalid = (count_r != 2'd0);
  assign out_tdata  = buf_r[rd_ptr_r];
  assign has_room   = (count_r != 2'd2);
  assign pop        = out_tvalid & out_tready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* tb/debounce_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// debounce_checker
// watches both streams of the input debouncer, predicts every result word
// from the accepted scans and compares it field by field in arrival order
// ---------------------------------------------------------------------------
module debounce_checker #(
  parameter int PORT_COUNT    = hrid_pkg::PORT_COUNT_DEF,
  parameter int HOLD_DEPTH    = hrid_pkg::HOLD_DEPTH_DEF,
  parameter int REPRESS_DEPTH = hrid_pkg::REPRESS_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  input  wire logic                       in_tready,
  input  wire logic [hrid_pkg::IN_W-1:0]  in_tdata,   // [31:0] sample_bits
  input  wire logic                       out_tvalid,
  input  wire logic                       out_tready,
  input  wire logic [hrid_pkg::OUT_W-1:0] out_tdata,  // [31:0] stable_bits, [39:32] changed_positions
  output int                              mismatch_count,
  output int                              pending_words
);

  localparam int LANES = (PORT_COUNT > hrid_pkg::WORD_PORTS) ? hrid_pkg::WORD_PORTS : PORT_COUNT;
  localparam logic [hrid_pkg::IN_W-1:0] LIVE_MASK =
    (LANES >= hrid_pkg::WORD_PORTS) ? '1 :
    ((32'd1 << (hrid_pkg::BYTE_W * LANES)) - 32'd1);
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [hrid_pkg::CHG_W-1:0] changed;
    logic [hrid_pkg::IN_W-1:0]  stable;
  } debounce_word_t;

  logic [hrid_pkg::IN_W-1:0] stable_vec;
  logic [hrid_pkg::IN_W-1:0] hold_hist [HOLD_DEPTH];
  logic [hrid_pkg::IN_W-1:0] repress_hist [REPRESS_DEPTH];
  int                        hold_ptr;
  int                        repress_ptr;
  debounce_word_t            pending_results [$];

  // one scan through the debouncer: rise gated by repress history, fall by hold history
  function automatic debounce_word_t debounce_scan(input logic [hrid_pkg::IN_W-1:0] raw);
    logic [hrid_pkg::IN_W-1:0] scan;
    logic [hrid_pkg::IN_W-1:0] repress_any;
    logic [hrid_pkg::IN_W-1:0] hold_any;
    logic [hrid_pkg::IN_W-1:0] nxt;
    logic [hrid_pkg::IN_W-1:0] diff;
    debounce_word_t            res;
    scan        = raw & LIVE_MASK;
    repress_any = '0;
    hold_any    = '0;
    for (int i = 0; i < REPRESS_DEPTH; i++) repress_any |= repress_hist[i];
    nxt = stable_vec | (scan & ~repress_any);
    // repress history takes the vector before the fall step
    repress_hist[repress_ptr] = nxt;
    hold_hist[hold_ptr]       = scan;
    for (int i = 0; i < HOLD_DEPTH; i++) hold_any |= hold_hist[i];
    nxt  = nxt & hold_any & LIVE_MASK;
    diff = nxt ^ stable_vec;
    res.stable  = nxt;
    res.changed = '0;
    for (int l = 0; l < hrid_pkg::WORD_PORTS; l++)
      res.changed |= diff[l*hrid_pkg::BYTE_W +: hrid_pkg::BYTE_W];
    stable_vec  = nxt;
    hold_ptr    = (hold_ptr + 1) % HOLD_DEPTH;
    repress_ptr = (repress_ptr + 1) % REPRESS_DEPTH;
    return res;
  endfunction

  task automatic note_mismatch(input string what, input logic [hrid_pkg::IN_W-1:0] want,
                               input logic [hrid_pkg::IN_W-1:0] got);
    if (mismatch_count < REPORT_LIMIT)
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    debounce_word_t want;
    debounce_word_t got;
    if (!rst_n) begin
      hold_ptr    = 0;
      repress_ptr = 0;
      stable_vec  = '0;
      for (int i = 0; i < HOLD_DEPTH; i++) hold_hist[i] = '0;
      for (int i = 0; i < REPRESS_DEPTH; i++) repress_hist[i] = '0;
      pending_results.delete();
      mismatch_count = 0;
    end else begin
      // result first: a word leaving now never belongs to the scan entering now
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (pending_results.size() == 0) begin
          note_mismatch("unexpected word", '0, got.stable);
        end else begin
          want = pending_results.pop_front();
          if (got.stable !== want.stable)
            note_mismatch("stable_bits", want.stable, got.stable);
          if (got.changed !== want.changed)
            note_mismatch("changed_positions", hrid_pkg::IN_W'(want.changed),
                          hrid_pkg::IN_W'(got.changed));
        end
      end
      if (in_tvalid && in_tready)
        pending_results.push_back(debounce_scan(in_tdata));
    end
    pending_words = pending_results.size();
  end

endmodule

/* tb/hold_repress_input_debouncer_core_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hold_repress_input_debouncer_core_test
// drives scan words into the debouncer with random gaps and back-pressure;
// a checker beside the block predicts and compares every result word
// ---------------------------------------------------------------------------
module hold_repress_input_debouncer_core_test;

  localparam int ITEMS_PER_PHASE = 510;
  localparam int DIRECTED_COUNT  = 25;

  logic                       clk;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [hrid_pkg::IN_W-1:0]  in_tdata;   // [31:0] sample_bits
  logic                       out_tvalid;
  logic                       out_tready;
  logic [hrid_pkg::OUT_W-1:0] out_tdata;  // [31:0] stable_bits, [39:32] changed_positions

  int mismatch_count;
  int pending_words;
  int in_idle_pct;
  int out_idle_pct;

  // pin model for the well-formed part: settled levels plus a bounce window
  logic [hrid_pkg::IN_W-1:0] settled_pins;
  int                        bounce_left;

  logic [hrid_pkg::IN_W-1:0] directed_scans [DIRECTED_COUNT];

  hold_repress_input_debouncer_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  debounce_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .pending_words  (pending_words)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure, redrawn at every falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // hands one scan word over; entered and left at a falling edge
  task automatic send_scan(input logic [hrid_pkg::IN_W-1:0] scan);
    // sender gap: valid drops for whole cycles only, never lowered and raised in one step
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= scan;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // next scan of the random part: mostly pins that settle after a bounce,
  // the rest raw noise or single all-low or all-high words
  function automatic logic [hrid_pkg::IN_W-1:0] next_scan();
    logic [hrid_pkg::IN_W-1:0] scan;
    int                        pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      if ($urandom_range(7) == 0) begin
        settled_pins ^= $urandom & $urandom & $urandom;
        bounce_left   = $urandom_range(6);
      end
      scan = settled_pins;
      if (bounce_left > 0) begin
        scan ^= $urandom & $urandom;
        bounce_left--;
      end
    end else if (pick < 85) begin
      scan = $urandom;
    end else if (pick < 93) begin
      scan = '0;
    end else begin
      scan = '1;
    end
    return scan;
  endfunction

  initial begin
    // known values from time zero
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_idle_pct  = 0;
    out_idle_pct = 0;
    settled_pins = '0;
    bounce_left  = 0;

    // all pins rise, held low until the hold history empties, then re-press
    // is blocked until the repress history clears; then walking and byte patterns
    directed_scans = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
      32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5,
      32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'h8000_0001, 32'h5A5A_5A5A, 32'h00FF_00FF, 32'hFF00_FF00,
      32'h0102_0408, 32'h1020_4080, 32'h0000_0000, 32'hFFFF_FFFF,
      32'h7FFF_FFFE
    };

    // synchronous reset, released at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed words with no idling on either side
    foreach (directed_scans[i]) send_scan(directed_scans[i]);

    // random words over three phases, the last with no idling on either side
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          in_idle_pct  = 28;
          out_idle_pct = 74;
        end
        1: begin
          in_idle_pct  = 74;
          out_idle_pct = 28;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_scan(next_scan());
    end
    in_tvalid <= 1'b0;

    // drain: every predicted word has to arrive, then a short settle
    while (pending_words != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* sim.f */
design/hrid_pkg.sv
design/hrid_lane.sv
design/hrid_merge.sv
design/hrid_outbuf.sv
design/hold_repress_input_debouncer_core.sv
tb/debounce_checker.sv
tb/hold_repress_input_debouncer_core_test.sv
